/* rtl/core/pmlod_pkg.sv */
package pmlod_pkg;

    localparam int DEF_COLLAPSE_DEPTH = 4096;
    localparam int DEF_INDEX_DEPTH    = 16384;

    localparam logic [31:0] TERM = 32'hFFFF_FFFF;
    localparam logic [16:0] VMAX = 17'h1_FFFF;
    localparam logic [14:0] IMAX = 15'd32766;

    // 2^16 / 3 rounded up, exact for the 15-bit range
    localparam logic [14:0] RECIP3 = 15'd21846;

    localparam logic [1:0] MODE_LOAD_TAB = 2'd0;
    localparam logic [1:0] MODE_LOAD_IDX = 2'd1;
    localparam logic [1:0] MODE_SET_TGT  = 2'd2;
    localparam logic [1:0] MODE_READ     = 2'd3;

    localparam logic [1:0] REG_EXPLICIT = 2'd0;
    localparam logic [1:0] REG_FULL_V   = 2'd1;
    localparam logic [1:0] REG_ENTRIES  = 2'd2;
    localparam logic [1:0] REG_FULL_I   = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD,
        ST_FIN,
        ST_DEC,
        ST_F1,
        ST_F2,
        ST_F3,
        ST_FWS,
        ST_TR0,
        ST_TR1,
        ST_TR2,
        ST_TR3,
        ST_PR0,
        ST_PRS,
        ST_PRF,
        ST_BS1,
        ST_BNV,
        ST_BCHK,
        ST_BWS
    } state_t;

    function automatic logic [16:0] sat_v(input logic [31:0] v);
        return (v > {15'd0, VMAX}) ? VMAX : v[16:0];
    endfunction

endpackage

/* rtl/core/progressive_mesh_lod_index_rewriter.sv */
// Level-of-detail index rewriter: the collapse table and the triangle index buffer sit in two
// synchronous memories with registered reads, and one sequencer walks them. Load items pass
// through the finish state only, read items through a read state first, and each then hands
// over its result. A set-target item reads, per forward record, the source, the destination
// and (in explicit mode) the new vertex count, writes one listed position a cycle, then trims
// degenerate triangles off the index end; per backward record it scans the table back one word
// a cycle to find the record start (twice in explicit mode) and then writes one position a
// cycle. The table read port sets that rate. The next item is taken while a result still waits.
module progressive_mesh_lod_index_rewriter
#(
    parameter int COLLAPSE_DEPTH = pmlod_pkg::DEF_COLLAPSE_DEPTH,
    parameter int INDEX_DEPTH    = pmlod_pkg::DEF_INDEX_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // address[13:0], word[45:14], target_vertices[62:46], zero fill
    input  logic [63:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_value[15:0], active_vertices[32:16], active_indices[47:33], reached[48],
    // record_position[61:49], zero fill
    output logic [63:0] m_tdata
);

    localparam int CAW = $clog2(COLLAPSE_DEPTH);
    localparam int IAW = $clog2(INDEX_DEPTH);
    localparam int PW  = $clog2(COLLAPSE_DEPTH + 8);

    pmlod_pkg::state_t state_reg, state_next;

    logic [31:0] tab_mem [COLLAPSE_DEPTH];
    logic [15:0] ib_mem  [INDEX_DEPTH];

    logic          explicit_reg;
    logic [16:0]   full_v_reg;
    logic [12:0]   entries_reg;
    logic [16:0]   vc_reg, vc_next;
    logic [14:0]   ic_reg, ic_next;
    logic [PW-1:0] pos_reg, pos_next;

    logic          back_reg, back_next;
    logic          pr2_reg, pr2_next;
    logic [PW-1:0] r_reg, r_next;
    logic [PW-1:0] c_reg, c_next;
    logic [PW-1:0] i_reg, i_next;
    logic [31:0]   src_reg, src_next;
    logic [15:0]   dst_reg, dst_next;
    logic [16:0]   nv_reg, nv_next;
    logic [15:0]   a_reg, a_next;
    logic [15:0]   b_reg, b_next;
    logic [16:0]   tgt_reg;
    logic [15:0]   rv_reg, rv_next;
    logic          rch_reg, rch_next;

    logic          out_valid_reg;
    logic [63:0]   out_data_reg;

    logic          tab_inr_reg;
    logic [31:0]   tab_q_reg;
    logic          ib_inr_reg;
    logic [15:0]   ib_q_reg;

    logic [PW-1:0] tab_ra;
    logic          tab_we;
    logic [16:0]   tab_wa;
    logic [31:0]   tab_wd;
    logic [16:0]   ib_ra;
    logic          ib_we;
    logic [16:0]   ib_wa;
    logic [15:0]   ib_wd;

    logic [PW-1:0] lim;
    logic [31:0]   tab_w;
    logic [15:0]   ib_v;
    logic          accept;
    logic          fwd_want;
    logic          w_term;
    logic          w_in_ib;
    logic          degen;
    logic          out_load;
    logic [14:0]   ic_grown;

    logic [1:0]    in_mode;
    logic [13:0]   in_addr;
    logic [31:0]   in_word;
    logic [16:0]   in_tgt;

    assign in_addr = s_tdata[13:0];
    assign in_word = s_tdata[45:14];
    assign in_tgt  = s_tdata[62:46];
    assign in_mode = s_tuser;

    assign s_tready = (state_reg == pmlod_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign lim = ({19'd0, entries_reg} < 32'(COLLAPSE_DEPTH))
               ? PW'(entries_reg) : PW'(COLLAPSE_DEPTH);
    assign tab_w    = tab_inr_reg ? tab_q_reg : pmlod_pkg::TERM;
    assign ib_v     = ib_inr_reg ? ib_q_reg : 16'd0;
    assign w_term   = (tab_w == pmlod_pkg::TERM);
    assign w_in_ib  = (tab_w < 32'(INDEX_DEPTH));
    assign fwd_want = !back_reg && (tgt_reg < vc_reg);
    assign degen    = (a_reg == b_reg) || (b_reg == ib_v) || (a_reg == ib_v);
    assign out_load = (state_reg == pmlod_pkg::ST_FIN) && (!out_valid_reg || m_tready);

    pmlod_grow u_grow
    (
        .w      (tab_w),
        .ic     (ic_reg),
        .ic_out (ic_grown)
    );

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_mem[tab_wa[CAW-1:0]] <= tab_wd;
        end
        tab_q_reg   <= tab_mem[tab_ra[CAW-1:0]];
        tab_inr_reg <= (tab_ra < lim);
    end

    always_ff @(posedge clk)
    begin
        if (ib_we)
        begin
            ib_mem[ib_wa[IAW-1:0]] <= ib_wd;
        end
        ib_q_reg   <= ib_mem[ib_ra[IAW-1:0]];
        ib_inr_reg <= ({15'd0, ib_ra} < 32'(INDEX_DEPTH));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pmlod_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_mode)
                        pmlod_pkg::MODE_SET_TGT: state_next = pmlod_pkg::ST_DEC;
                        pmlod_pkg::MODE_READ:    state_next = pmlod_pkg::ST_RD;
                        default:                 state_next = pmlod_pkg::ST_FIN;
                    endcase
                end
            end
            pmlod_pkg::ST_RD:  state_next = pmlod_pkg::ST_FIN;
            pmlod_pkg::ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = pmlod_pkg::ST_IDLE;
                end
            end
            pmlod_pkg::ST_DEC:
            begin
                if (fwd_want)
                begin
                    if (pos_reg < lim)
                    begin
                        state_next = pmlod_pkg::ST_F1;
                    end
                end
                else if (tgt_reg > vc_reg && pos_reg != '0)
                begin
                    state_next = pmlod_pkg::ST_PR0;
                end
                else
                begin
                    state_next = pmlod_pkg::ST_FIN;
                end
            end
            pmlod_pkg::ST_F1:  state_next = pmlod_pkg::ST_F2;
            pmlod_pkg::ST_F2:  state_next = explicit_reg ? pmlod_pkg::ST_F3 : pmlod_pkg::ST_FWS;
            pmlod_pkg::ST_F3:  state_next = pmlod_pkg::ST_FWS;
            pmlod_pkg::ST_FWS:
            begin
                if (w_term)
                begin
                    state_next = pmlod_pkg::ST_TR0;
                end
            end
            pmlod_pkg::ST_TR0:
            begin
                state_next = (ic_reg >= 15'd3) ? pmlod_pkg::ST_TR1 : pmlod_pkg::ST_DEC;
            end
            pmlod_pkg::ST_TR1: state_next = pmlod_pkg::ST_TR2;
            pmlod_pkg::ST_TR2: state_next = pmlod_pkg::ST_TR3;
            pmlod_pkg::ST_TR3: state_next = degen ? pmlod_pkg::ST_TR0 : pmlod_pkg::ST_DEC;
            pmlod_pkg::ST_PR0:
            begin
                state_next = (i_reg == '0) ? pmlod_pkg::ST_PRF : pmlod_pkg::ST_PRS;
            end
            pmlod_pkg::ST_PRS:
            begin
                if (w_term || i_reg == PW'(1))
                begin
                    state_next = pmlod_pkg::ST_PRF;
                end
            end
            pmlod_pkg::ST_PRF: state_next = pr2_reg ? pmlod_pkg::ST_BNV : pmlod_pkg::ST_BS1;
            pmlod_pkg::ST_BS1:
            begin
                if (!explicit_reg)
                begin
                    state_next = pmlod_pkg::ST_BWS;
                end
                else if (c_reg != '0)
                begin
                    state_next = pmlod_pkg::ST_PR0;
                end
                else
                begin
                    state_next = pmlod_pkg::ST_BCHK;
                end
            end
            pmlod_pkg::ST_BNV: state_next = pmlod_pkg::ST_BCHK;
            pmlod_pkg::ST_BCHK:
            begin
                state_next = (nv_reg > tgt_reg) ? pmlod_pkg::ST_FIN : pmlod_pkg::ST_BWS;
            end
            pmlod_pkg::ST_BWS:
            begin
                if (w_term)
                begin
                    state_next = pmlod_pkg::ST_DEC;
                end
            end
            default: state_next = pmlod_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        vc_next   = vc_reg;
        ic_next   = ic_reg;
        pos_next  = pos_reg;
        back_next = back_reg;
        pr2_next  = pr2_reg;
        r_next    = r_reg;
        c_next    = c_reg;
        i_next    = i_reg;
        src_next  = src_reg;
        dst_next  = dst_reg;
        nv_next   = nv_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        rv_next   = rv_reg;
        rch_next  = rch_reg;
        tab_ra    = '0;
        tab_we    = 1'b0;
        tab_wa    = {3'd0, in_addr};
        tab_wd    = in_word;
        ib_ra     = {3'd0, in_addr};
        ib_we     = 1'b0;
        ib_wa     = {3'd0, in_addr};
        ib_wd     = in_word[15:0];
        case (state_reg)
            pmlod_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    rv_next   = 16'd0;
                    rch_next  = 1'b0;
                    back_next = 1'b0;
                    case (in_mode)
                        pmlod_pkg::MODE_LOAD_TAB:
                        begin
                            tab_we = ({18'd0, in_addr} < 32'(COLLAPSE_DEPTH));
                        end
                        pmlod_pkg::MODE_LOAD_IDX:
                        begin
                            ib_we = ({18'd0, in_addr} < 32'(INDEX_DEPTH));
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            pmlod_pkg::ST_RD:
            begin
                rv_next = ib_v;
            end
            pmlod_pkg::ST_DEC:
            begin
                if (fwd_want)
                begin
                    if (pos_reg < lim)
                    begin
                        tab_ra = pos_reg;
                    end
                    else
                    begin
                        back_next = 1'b1;
                    end
                end
                else if (tgt_reg > vc_reg && pos_reg != '0)
                begin
                    i_next   = pos_reg - PW'(1);
                    pr2_next = 1'b0;
                end
                else
                begin
                    rch_next = (tgt_reg == vc_reg);
                end
            end
            pmlod_pkg::ST_F1:
            begin
                src_next = tab_w;
                tab_ra   = pos_reg + PW'(1);
            end
            pmlod_pkg::ST_F2:
            begin
                dst_next = tab_w[15:0];
                tab_ra   = pos_reg + PW'(2);
                if (!explicit_reg)
                begin
                    r_next = pos_reg + PW'(2);
                    if (vc_reg != 17'd0 && src_reg == {15'd0, vc_reg} - 32'd1)
                    begin
                        vc_next = vc_reg - 17'd1;
                    end
                end
            end
            pmlod_pkg::ST_F3:
            begin
                vc_next = pmlod_pkg::sat_v(tab_w);
                r_next  = pos_reg + PW'(3);
                tab_ra  = pos_reg + PW'(3);
            end
            pmlod_pkg::ST_FWS:
            begin
                if (w_term)
                begin
                    pos_next = r_reg + PW'(1);
                end
                else
                begin
                    ib_we  = w_in_ib;
                    ib_wa  = tab_w[16:0];
                    ib_wd  = dst_reg;
                    r_next = r_reg + PW'(1);
                    tab_ra = r_reg + PW'(1);
                end
            end
            pmlod_pkg::ST_TR0:
            begin
                ib_ra = {2'd0, ic_reg - 15'd3};
            end
            pmlod_pkg::ST_TR1:
            begin
                a_next = ib_v;
                ib_ra  = {2'd0, ic_reg - 15'd2};
            end
            pmlod_pkg::ST_TR2:
            begin
                b_next = ib_v;
                ib_ra  = {2'd0, ic_reg - 15'd1};
            end
            pmlod_pkg::ST_TR3:
            begin
                if (degen)
                begin
                    ic_next = ic_reg - 15'd3;
                end
            end
            pmlod_pkg::ST_PR0:
            begin
                tab_ra = i_reg - PW'(1);
            end
            pmlod_pkg::ST_PRS:
            begin
                if (!w_term)
                begin
                    i_next = i_reg - PW'(1);
                    tab_ra = i_reg - PW'(2);
                end
            end
            pmlod_pkg::ST_PRF:
            begin
                if (pr2_reg)
                begin
                    tab_ra = i_reg + PW'(2);
                end
                else
                begin
                    c_next = i_reg;
                    tab_ra = i_reg;
                end
            end
            pmlod_pkg::ST_BS1:
            begin
                src_next = tab_w;
                if (!explicit_reg)
                begin
                    if (tab_w == {15'd0, vc_reg})
                    begin
                        vc_next = (vc_reg == pmlod_pkg::VMAX) ? pmlod_pkg::VMAX
                                                             : vc_reg + 17'd1;
                    end
                    r_next = c_reg + PW'(2);
                    tab_ra = c_reg + PW'(2);
                end
                else if (c_reg != '0)
                begin
                    i_next   = c_reg - PW'(1);
                    pr2_next = 1'b1;
                end
                else
                begin
                    nv_next = full_v_reg;
                end
            end
            pmlod_pkg::ST_BNV:
            begin
                nv_next = pmlod_pkg::sat_v(tab_w);
            end
            pmlod_pkg::ST_BCHK:
            begin
                if (nv_reg > tgt_reg)
                begin
                    rch_next = (tgt_reg == vc_reg);
                end
                else
                begin
                    vc_next = nv_reg;
                    r_next  = c_reg + PW'(3);
                    tab_ra  = c_reg + PW'(3);
                end
            end
            pmlod_pkg::ST_BWS:
            begin
                if (w_term)
                begin
                    pos_next = c_reg;
                end
                else
                begin
                    ic_next = ic_grown;
                    ib_we   = w_in_ib;
                    ib_wa   = tab_w[16:0];
                    ib_wd   = src_reg[15:0];
                    r_next  = r_reg + PW'(1);
                    tab_ra  = r_reg + PW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pmlod_pkg::ST_IDLE;
            explicit_reg  <= 1'b0;
            full_v_reg    <= '0;
            entries_reg   <= '0;
            vc_reg        <= '0;
            ic_reg        <= '0;
            pos_reg       <= '0;
            back_reg      <= 1'b0;
            pr2_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            back_reg  <= back_next;
            pr2_reg   <= pr2_next;
            vc_reg    <= vc_next;
            ic_reg    <= ic_next;
            pos_reg   <= pos_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    pmlod_pkg::REG_EXPLICIT:
                    begin
                        explicit_reg <= cfg_data[0];
                        pos_reg      <= '0;
                    end
                    pmlod_pkg::REG_FULL_V:
                    begin
                        full_v_reg <= cfg_data;
                        vc_reg     <= cfg_data;
                    end
                    pmlod_pkg::REG_ENTRIES:
                    begin
                        entries_reg <= cfg_data[12:0];
                        pos_reg     <= '0;
                    end
                    pmlod_pkg::REG_FULL_I:
                    begin
                        ic_reg <= cfg_data[14:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg   <= r_next;
        c_reg   <= c_next;
        i_reg   <= i_next;
        src_reg <= src_next;
        dst_reg <= dst_next;
        nv_reg  <= nv_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        rv_reg  <= rv_next;
        rch_reg <= rch_next;
        if (accept)
        begin
            tgt_reg <= in_tgt;
        end
        if (out_load)
        begin
            out_data_reg <= {2'd0, 13'(pos_reg), rch_reg, ic_reg, vc_reg, rv_reg};
        end
    end

endmodule

/* rtl/core/pmlod_grow.sv */
module pmlod_grow
(
    input  logic [31:0] w,
    input  logic [14:0] ic,
    output logic [14:0] ic_out
);

    logic [29:0] prod;
    logic [13:0] quot;
    logic [14:0] grown;

    // floor(w / 3) by reciprocal, valid for w below 32766
    assign prod  = w[14:0] * pmlod_pkg::RECIP3;
    assign quot  = prod[29:16];
    assign grown = 15'(({1'b0, quot} + 15'd1) * 15'd3);

    always_comb
    begin
        if (w >= {17'd0, ic})
        begin
            if (w >= {17'd0, pmlod_pkg::IMAX})
            begin
                ic_out = pmlod_pkg::IMAX;
            end
            else
            begin
                ic_out = grown;
            end
        end
        else
        begin
            ic_out = ic;
        end
    end

endmodule

/* rtl/core/pmlod_checker.sv */
module pmlod_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // the sequencer is busy in the cycle after every accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on consecutive cycles");

    // a result appears only after the sequencer has been busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result without preceding work");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

    // fill bits above the record position stay clear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[63:62] == 2'd0)
    else $error("fill bits set");

endmodule

bind progressive_mesh_lod_index_rewriter pmlod_checker u_pmlod_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
